// ----- rtl/wlbc_pkg.sv -----
`default_nettype none
package wlbc_pkg;

    localparam int SLOTS   = 64;
    localparam int DEVICES = 32;
    localparam int ADDR_W  = 48;
    localparam int DEV_W   = 5;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CNT_W   = 7;
    localparam int CMD_W   = 3;
    localparam int STAT_W  = 3;
    localparam int TICK_W  = 32;

    // request commands
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FLUSH = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SYNC  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_INVAL = 3'd4;
    localparam logic [CMD_W-1:0] CMD_ABORT = 3'd5;

    // result status codes
    localparam logic [STAT_W-1:0] ST_READ_HIT  = 3'd0;
    localparam logic [STAT_W-1:0] ST_READ_MISS = 3'd1;
    localparam logic [STAT_W-1:0] ST_WRITE_HIT = 3'd2;
    localparam logic [STAT_W-1:0] ST_WRITE_MISS = 3'd3;
    localparam logic [STAT_W-1:0] ST_FLUSH_WB  = 3'd4;
    localparam logic [STAT_W-1:0] ST_NOTHING   = 3'd5;
    localparam logic [STAT_W-1:0] ST_ABORT     = 3'd6;

    typedef enum logic [1:0] {
        K_ACCESS,
        K_WALK,
        K_ABORT,
        K_NOP
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               is_write;
        logic               all;
        logic               drop;
        logic [DEV_W-1:0]   dev;
        logic [ADDR_W-1:0]  addr;
        logic [SLOT_W-1:0]  fs;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [SLOT_W-1:0]  slot;
        logic               wb;
        logic [DEV_W-1:0]   wdev;
        logic [ADDR_W-1:0]  waddr;
        logic               last;
    } t_res;

endpackage
`default_nettype wire

// ----- rtl/wlbc_front.sv -----
`default_nettype none
module wlbc_front import wlbc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [CMD_W-1:0]  i_command,
    input  wire logic [DEV_W-1:0]  i_device,
    input  wire logic [ADDR_W-1:0] i_address,
    input  wire logic [SLOT_W-1:0] i_fill_slot,
    output logic                   o_req_valid,
    output t_req                   o_req,
    input  wire logic              i_req_pop
);

    t_req        r_q [2];
    logic        r_wr;
    logic        r_rd;
    logic [1:0]  r_cnt;
    t_req        n_req;
    logic        dev_ok;
    logic        push;

    // classify the incoming beat
    always_comb begin
        dev_ok         = ({1'b0, i_device} < (DEV_W+1)'(DEVICES));
        n_req.is_write = (i_command == CMD_WRITE);
        n_req.all      = (i_command == CMD_SYNC);
        n_req.drop     = (i_command == CMD_INVAL);
        n_req.dev      = i_device;
        n_req.addr     = i_address;
        n_req.fs       = i_fill_slot;
        case (i_command)
            CMD_READ, CMD_WRITE, CMD_FLUSH, CMD_INVAL: begin
                n_req.kind = (i_command == CMD_FLUSH || i_command == CMD_INVAL) ?
                             K_WALK : K_ACCESS;
                if (!dev_ok) n_req.kind = K_NOP;
            end
            CMD_SYNC:  n_req.kind = K_WALK;
            CMD_ABORT: n_req.kind = K_ABORT;
            default:   n_req.kind = K_NOP;
        endcase
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign push        = i_valid && o_ready;
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_q[r_rd];

    // two-entry queue towards the back end
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr] <= n_req;
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (i_req_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(push) - 2'(i_req_pop);
        end
    end

endmodule
`default_nettype wire

// ----- rtl/wlbc_back.sv -----
`default_nettype none
module wlbc_back import wlbc_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [CNT_W-1:0] i_entries,
    input  wire logic             i_req_valid,
    input  wire t_req             i_req,
    output logic                  o_req_pop,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output t_res                  o_res
);

    typedef enum logic [1:0] {S_IDLE, S_RD, S_EV, S_DONE} t_state;

    localparam int KEY_W = DEV_W + ADDR_W;

    t_state              r_state;
    t_req                r_req;
    logic [SLOT_W-1:0]   r_idx;
    logic [SLOTS-1:0]    r_valid;
    logic [SLOTS-1:0]    r_dirty;
    logic [TICK_W-1:0]   r_tick;
    logic [KEY_W-1:0]    key_mem [SLOTS];
    logic [TICK_W-1:0]   use_mem [SLOTS];
    logic [KEY_W-1:0]    r_key_q;
    logic [TICK_W-1:0]   r_use_q;
    logic                r_hit;
    logic [SLOT_W-1:0]   r_hidx;
    logic                r_inv;
    logic [SLOT_W-1:0]   r_vidx;
    logic                r_bset;
    logic [SLOT_W-1:0]   r_bidx;
    logic [TICK_W-1:0]   r_buse;
    logic [KEY_W-1:0]    r_bkey;
    logic                r_bdirty;
    logic                r_pend_v;
    t_res                r_pend;
    logic                r_ov;
    t_res                r_out;

    logic [CNT_W-1:0]    n_cnt;
    logic                out_free;
    logic                at_end;
    logic                cur_v;
    logic                cur_d;
    logic                key_hit;
    logic                walk_match;
    logic [TICK_W-1:0]   n_tick;
    logic [SLOT_W-1:0]   victim;
    logic                key_we;
    logic                use_we;
    logic [SLOT_W-1:0]   use_wa;
    logic                emit;
    t_res                n_out;

    // clamp the slot count to 1..SLOTS
    always_comb begin
        if (i_entries == '0)                   n_cnt = CNT_W'(1);
        else if (i_entries > CNT_W'(SLOTS))    n_cnt = CNT_W'(SLOTS);
        else                                   n_cnt = i_entries;
    end

    assign out_free   = !r_ov || i_ready;
    assign at_end     = ({1'b0, r_idx} == n_cnt - CNT_W'(1));
    assign cur_v      = r_valid[r_idx];
    assign cur_d      = r_dirty[r_idx];
    assign key_hit    = cur_v && (r_key_q == {r_req.dev, r_req.addr});
    assign walk_match = cur_v && (r_req.all || r_key_q[KEY_W-1:ADDR_W] == r_req.dev);
    assign n_tick     = r_tick + TICK_W'(1);
    assign victim     = r_inv ? r_vidx : r_bidx;
    assign o_req_pop  = (r_state == S_IDLE) && i_req_valid;
    assign o_valid    = r_ov;
    assign o_res      = r_out;

    // load the output register on a closing beat or a released write-back
    assign emit = ((r_state == S_DONE) && out_free) ||
                  ((r_state == S_EV) && (r_req.kind != K_ACCESS) && walk_match && cur_d &&
                   r_pend_v && out_free);

    // closing beat of the current request
    always_comb begin
        n_out      = '0;
        n_out.last = 1'b1;
        case (r_req.kind)
            K_ACCESS: begin
                if (r_hit) begin
                    n_out.status = r_req.is_write ? ST_WRITE_HIT : ST_READ_HIT;
                    n_out.slot   = r_hidx;
                end else begin
                    n_out.status = r_req.is_write ? ST_WRITE_MISS : ST_READ_MISS;
                    n_out.slot   = victim;
                    if (!r_inv && r_bdirty) begin
                        n_out.wb    = 1'b1;
                        n_out.wdev  = r_bkey[KEY_W-1:ADDR_W];
                        n_out.waddr = r_bkey[ADDR_W-1:0];
                    end
                end
            end
            K_WALK: begin
                if (r_pend_v) begin
                    n_out      = r_pend;
                    n_out.last = 1'b1;
                end else begin
                    n_out.status = ST_NOTHING;
                end
            end
            K_ABORT: begin
                n_out.status = ST_ABORT;
                n_out.slot   = r_req.fs;
            end
            default: n_out.status = ST_NOTHING;
        endcase
    end

    // memory write strobes, only in the closing step of an access
    always_comb begin
        key_we = (r_state == S_DONE) && out_free && (r_req.kind == K_ACCESS) && !r_hit;
        use_we = (r_state == S_DONE) && out_free && (r_req.kind == K_ACCESS);
        use_wa = r_hit ? r_hidx : victim;
    end

    // tag and use-tick memories, registered read
    always_ff @(posedge i_clk) begin
        if (key_we) key_mem[victim] <= {r_req.dev, r_req.addr};
        if (use_we) use_mem[use_wa] <= n_tick;
        r_key_q <= key_mem[r_idx];
        r_use_q <= use_mem[r_idx];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_dirty  <= '0;
            r_tick   <= '0;
            r_ov     <= 1'b0;
            r_pend_v <= 1'b0;
            r_hit    <= 1'b0;
            r_inv    <= 1'b0;
            r_bset   <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_ov <= emit || (r_ov && !i_ready);
            case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_req    <= i_req;
                        r_idx    <= '0;
                        r_hit    <= 1'b0;
                        r_inv    <= 1'b0;
                        r_bset   <= 1'b0;
                        r_pend_v <= 1'b0;
                        r_state  <= (i_req.kind == K_ACCESS || i_req.kind == K_WALK) ?
                                    S_RD : S_DONE;
                    end
                end
                S_RD: r_state <= S_EV;
                S_EV: begin
                    if (r_req.kind == K_ACCESS) begin
                        // track hit, first free slot and oldest slot
                        if (key_hit && !r_hit) begin
                            r_hit  <= 1'b1;
                            r_hidx <= r_idx;
                        end
                        if (!cur_v && !r_inv) begin
                            r_inv  <= 1'b1;
                            r_vidx <= r_idx;
                        end
                        if (cur_v && (!r_bset || r_use_q < r_buse)) begin
                            r_bset   <= 1'b1;
                            r_bidx   <= r_idx;
                            r_buse   <= r_use_q;
                            r_bkey   <= r_key_q;
                            r_bdirty <= cur_d;
                        end
                        r_idx   <= r_idx + SLOT_W'(1);
                        r_state <= at_end ? S_DONE : S_RD;
                    end else if (!(walk_match && cur_d && r_pend_v && !out_free)) begin
                        // emit previous write-back, hold the new one for last marking
                        if (walk_match && cur_d) begin
                            if (r_pend_v) r_out <= r_pend;
                            r_pend_v      <= 1'b1;
                            r_pend.status <= ST_FLUSH_WB;
                            r_pend.slot   <= r_idx;
                            r_pend.wb     <= 1'b1;
                            r_pend.wdev   <= r_key_q[KEY_W-1:ADDR_W];
                            r_pend.waddr  <= r_key_q[ADDR_W-1:0];
                            r_pend.last   <= 1'b0;
                            r_dirty[r_idx] <= 1'b0;
                        end
                        if (walk_match && r_req.drop) r_valid[r_idx] <= 1'b0;
                        r_idx   <= r_idx + SLOT_W'(1);
                        r_state <= at_end ? S_DONE : S_RD;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out   <= n_out;
                        r_state <= S_IDLE;
                        case (r_req.kind)
                            K_ACCESS: begin
                                r_tick <= n_tick;
                                if (r_hit) begin
                                    if (r_req.is_write) r_dirty[r_hidx] <= 1'b1;
                                end else begin
                                    r_valid[victim] <= 1'b1;
                                    r_dirty[victim] <= r_req.is_write;
                                end
                            end
                            K_ABORT: begin
                                r_valid[r_req.fs] <= 1'b0;
                                r_dirty[r_req.fs] <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/writeback_lru_block_cache_tags_core.sv -----
`default_nettype none
// Tag and LRU controller of a write-back, fully associative block cache with up to 64 slots.
// Requests enter on the slave stream (command in tuser) and are queued two deep; the back
// end walks the tag memory slot by slot, a read state and then an evaluate state per slot,
// since the keys and use ticks sit in memories with a registered read. An abort skips the
// walk; a flush, sync or invalidate walk can stall on the output while a write-back waits.
// Results leave through a one-beat output register; tlast marks the final beat of each
// request. No clearing pass is needed after reset.
module writeback_lru_block_cache_tags_core import wlbc_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [6:0]  i_cfg_wr_data,   // entries_in_use
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,    // device[4:0], block_address[52:5], fill_slot[58:53]
    input  wire logic [2:0]  s_axis_tuser,    // command
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,         // slot[5:0], writeback[6], writeback_device[11:7],
                                              // writeback_address[59:12]
    output logic [2:0]  m_axis_tuser,         // status
    output logic        m_axis_tlast          // last
);

    logic [CNT_W-1:0] r_entries;
    logic             req_valid;
    t_req             req;
    logic             req_pop;
    t_res             res;

    // slot count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_entries <= CNT_W'(SLOTS);
        else if (i_cfg_wr_en) r_entries <= i_cfg_wr_data;
    end

    wlbc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_command   (s_axis_tuser),
        .i_device    (s_axis_tdata[4:0]),
        .i_address   (s_axis_tdata[52:5]),
        .i_fill_slot (s_axis_tdata[58:53]),
        .o_req_valid (req_valid),
        .o_req       (req),
        .i_req_pop   (req_pop)
    );

    wlbc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_entries   (r_entries),
        .i_req_valid (req_valid),
        .i_req       (req),
        .o_req_pop   (req_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_res       (res)
    );

    assign m_axis_tdata = {4'd0, res.waddr, res.wdev, res.wb, res.slot};
    assign m_axis_tuser = res.status;
    assign m_axis_tlast = res.last;

    // no write-back key without the write-back flag
    a_wb_key_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[6]) |-> (m_axis_tdata[59:7] == '0))
        else $error("write-back key set without write-back");

    // nothing, abort and hit answers are single-beat and always close the request
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_NOTHING || m_axis_tuser == ST_ABORT ||
         m_axis_tuser == ST_READ_HIT || m_axis_tuser == ST_WRITE_HIT)) |-> m_axis_tlast)
        else $error("single-beat result without tlast");

    // flush beats always carry a write-back
    a_flush_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_FLUSH_WB) |-> m_axis_tdata[6])
        else $error("flush beat without write-back");

    // status code stays within the defined set
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser != 3'd7))
        else $error("undefined status code");

endmodule
`default_nettype wire

// ----- sim/writeback_lru_block_cache_tags_core_tb.sv -----
`timescale 1ns / 1ps

module writeback_lru_block_cache_tags_core_tb;
    import wlbc_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 300;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_wr_en = 1'b0;
    logic [6:0]        i_cfg_wr_data = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [63:0]       s_axis_tdata = '0;
    logic [2:0]        s_axis_tuser = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [63:0]       m_axis_tdata;
    logic [2:0]        m_axis_tuser;
    logic              m_axis_tlast;

    writeback_lru_block_cache_tags_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // tag store mirror
    logic              tag_valid [SLOTS];
    logic              tag_dirty [SLOTS];
    logic [DEV_W-1:0]  tag_dev   [SLOTS];
    logic [ADDR_W-1:0] tag_addr  [SLOTS];
    logic [TICK_W-1:0] tag_used  [SLOTS];
    logic [TICK_W-1:0] tick_now;
    logic [6:0]        slots_reg;

    t_res pending_results [$];

    int errors      = 0;
    int cycles      = 0;
    int beats_sent  = 0;
    int beats_seen  = 0;
    int writebacks  = 0;
    int stall_pct   = 0;
    int gap_max     = 0;
    int burst_left  = 0;

    // key pool for the random phases, so that hits and evictions happen
    logic [DEV_W-1:0]  pool_dev  [128];
    logic [ADDR_W-1:0] pool_addr [128];
    int                pool_size = 8;

    // cycle counter and timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (stall_pct == 0)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (errors < 30)
            $display("mismatch at beat %0d: %s got %0h expected %0h", beats_seen, what,
                     got, want);
        errors++;
    endtask

    // compare each result beat with the oldest expectation
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected beat", m_axis_tdata, 64'd0);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser != want.status)
                    report_mismatch("status", 64'(m_axis_tuser), 64'(want.status));
                if (m_axis_tdata[5:0] != want.slot)
                    report_mismatch("slot", 64'(m_axis_tdata[5:0]), 64'(want.slot));
                if (m_axis_tdata[6] != want.wb)
                    report_mismatch("writeback", 64'(m_axis_tdata[6]), 64'(want.wb));
                if (m_axis_tdata[11:7] != want.wdev)
                    report_mismatch("wb device", 64'(m_axis_tdata[11:7]), 64'(want.wdev));
                if (m_axis_tdata[59:12] != want.waddr)
                    report_mismatch("wb address", 64'(m_axis_tdata[59:12]),
                                    64'(want.waddr));
                if (m_axis_tlast != want.last)
                    report_mismatch("last", 64'(m_axis_tlast), 64'(want.last));
                if (want.wb)
                    writebacks++;
            end
            beats_seen++;
        end
    end

    function automatic int slots_active();
        if (slots_reg < 1)
            return 1;
        if (slots_reg > SLOTS)
            return SLOTS;
        return slots_reg;
    endfunction

    function automatic t_res make_result(logic [STAT_W-1:0] st, int s, logic wb,
                                         logic [DEV_W-1:0] d, logic [ADDR_W-1:0] a,
                                         logic lst);
        t_res r;
        r.status = st;
        r.slot   = s[SLOT_W-1:0];
        r.wb     = wb;
        r.wdev   = wb ? d : '0;
        r.waddr  = wb ? a : '0;
        r.last   = lst;
        return r;
    endfunction

    // lookup, allocate or walk the mirrored tags and queue the expected beats
    function automatic void predict_request(logic [CMD_W-1:0] cmd, logic [DEV_W-1:0] d,
                                            logic [ADDR_W-1:0] a, logic [SLOT_W-1:0] fs);
        int n;
        int v;
        int hit;
        int cnt;
        logic wb;
        logic [TICK_W-1:0] oldest;
        n = slots_active();
        hit = -1;
        cnt = 0;
        case (cmd)
            CMD_READ, CMD_WRITE: begin
                for (int i = 0; i < n; i++)
                    if (hit < 0 && tag_valid[i] && tag_dev[i] == d && tag_addr[i] == a)
                        hit = i;
                if (hit >= 0) begin
                    tick_now = tick_now + 1;
                    tag_used[hit] = tick_now;
                    if (cmd == CMD_WRITE)
                        tag_dirty[hit] = 1'b1;
                    pending_results.push_back(make_result(
                        (cmd == CMD_WRITE) ? ST_WRITE_HIT : ST_READ_HIT, hit, 1'b0, '0, '0,
                        1'b1));
                end else begin
                    v = -1;
                    for (int i = 0; i < n; i++)
                        if (v < 0 && !tag_valid[i])
                            v = i;
                    if (v < 0) begin
                        v = 0;
                        oldest = tag_used[0];
                        for (int i = 1; i < n; i++)
                            if (tag_used[i] < oldest) begin
                                oldest = tag_used[i];
                                v = i;
                            end
                    end
                    wb = tag_valid[v] && tag_dirty[v];
                    pending_results.push_back(make_result(
                        (cmd == CMD_WRITE) ? ST_WRITE_MISS : ST_READ_MISS, v, wb,
                        tag_dev[v], tag_addr[v], 1'b1));
                    tag_valid[v] = 1'b1;
                    tag_dirty[v] = (cmd == CMD_WRITE);
                    tag_dev[v]   = d;
                    tag_addr[v]  = a;
                    tick_now = tick_now + 1;
                    tag_used[v] = tick_now;
                end
            end
            CMD_FLUSH, CMD_SYNC, CMD_INVAL: begin
                for (int i = 0; i < n; i++) begin
                    if (tag_valid[i] && (cmd == CMD_SYNC || tag_dev[i] == d)) begin
                        if (tag_dirty[i]) begin
                            pending_results.push_back(make_result(ST_FLUSH_WB, i, 1'b1,
                                tag_dev[i], tag_addr[i], 1'b0));
                            tag_dirty[i] = 1'b0;
                            cnt++;
                        end
                        if (cmd == CMD_INVAL)
                            tag_valid[i] = 1'b0;
                    end
                end
                if (cnt == 0)
                    pending_results.push_back(make_result(ST_NOTHING, 0, 1'b0, '0, '0,
                                                          1'b1));
                else
                    pending_results[pending_results.size() - 1].last = 1'b1;
            end
            CMD_ABORT: begin
                tag_valid[fs] = 1'b0;
                tag_dirty[fs] = 1'b0;
                pending_results.push_back(make_result(ST_ABORT, fs, 1'b0, '0, '0, 1'b1));
            end
            default: begin
                pending_results.push_back(make_result(ST_NOTHING, 0, 1'b0, '0, '0, 1'b1));
            end
        endcase
    endfunction

    // send one request beat, with bursts and random gaps
    task automatic send_request(logic [CMD_W-1:0] cmd, logic [DEV_W-1:0] d,
                                logic [ADDR_W-1:0] a, logic [SLOT_W-1:0] fs);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        predict_request(cmd, d, a, fs);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {5'd0, fs, a, d};
        do @(posedge i_clk); while (!s_axis_tready);
        beats_sent++;
    endtask

    // drop valid and hold until every expected beat has come and the walk is over
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_slot_count(logic [6:0] value);
        drain_results();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        slots_reg = value;
    endtask

    function automatic logic [ADDR_W-1:0] rand_addr();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return ADDR_W'({$urandom, $urandom});
        endcase
    endfunction

    task automatic test_basic_access();
        send_request(CMD_READ, 5'd3, 48'h1234_5678_9abc, 6'd0);
        send_request(CMD_READ, 5'd3, 48'h1234_5678_9abc, 6'd0);
        send_request(CMD_WRITE, 5'd3, 48'h1234_5678_9abc, 6'd0);
        send_request(CMD_WRITE, 5'd31, '1, 6'd63);
        send_request(CMD_READ, 5'd0, '0, 6'd0);
        send_request(CMD_FLUSH, 5'd31, '0, 6'd0);
        send_request(CMD_FLUSH, 5'd31, '0, 6'd0);
        send_request(CMD_SYNC, 5'd0, '0, 6'd0);
        send_request(CMD_WRITE, 5'd0, '0, 6'd0);
        send_request(CMD_INVAL, 5'd0, '0, 6'd0);
        send_request(CMD_READ, 5'd0, '0, 6'd0);
        send_request(CMD_ABORT, 5'd0, '0, 6'd63);
        send_request(CMD_ABORT, 5'd0, '0, 6'd0);
        send_request(3'd6, 5'd31, '1, 6'd63);
        send_request(3'd7, 5'd0, '0, 6'd0);
    endtask

    // small caches: dirty victims, clamping of the slot count
    task automatic test_eviction();
        write_slot_count(7'd2);
        send_request(CMD_WRITE, 5'd1, 48'h10, 6'd0);
        send_request(CMD_WRITE, 5'd2, 48'h20, 6'd0);
        send_request(CMD_READ, 5'd1, 48'h10, 6'd0);
        send_request(CMD_WRITE, 5'd3, 48'h30, 6'd0);
        send_request(CMD_READ, 5'd4, 48'h40, 6'd0);
        write_slot_count(7'd0);
        send_request(CMD_WRITE, 5'd5, 48'h50, 6'd0);
        send_request(CMD_WRITE, 5'd6, 48'h60, 6'd0);
        write_slot_count(7'd127);
        send_request(CMD_SYNC, 5'd0, '0, 6'd0);
    endtask

    // random phase: mostly accesses on a key pool, the rest walks, aborts and noise
    task automatic test_random_phase(logic [6:0] count, int items, int pool, int pct,
                                     int gmax);
        int k;
        int pick;
        write_slot_count(count);
        stall_pct = pct;
        gap_max   = gmax;
        pool_size = pool;
        for (int i = 0; i < pool; i++) begin
            pool_dev[i]  = DEV_W'($urandom_range(0, 31));
            pool_addr[i] = rand_addr();
        end
        for (int i = 0; i < items; i++) begin
            k = $urandom_range(0, pool_size - 1);
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_request(CMD_READ, pool_dev[k], pool_addr[k], SLOT_W'($urandom));
            else if (pick < 82)
                send_request(CMD_WRITE, pool_dev[k], pool_addr[k], SLOT_W'($urandom));
            else if (pick < 86)
                send_request(CMD_FLUSH, pool_dev[k], rand_addr(), SLOT_W'($urandom));
            else if (pick < 89)
                send_request(CMD_SYNC, DEV_W'($urandom), rand_addr(), SLOT_W'($urandom));
            else if (pick < 92)
                send_request(CMD_INVAL, pool_dev[k], rand_addr(), SLOT_W'($urandom));
            else if (pick < 96)
                send_request(CMD_ABORT, DEV_W'($urandom), rand_addr(), SLOT_W'($urandom));
            else if (pick < 98)
                send_request(CMD_W'($urandom_range(6, 7)), DEV_W'($urandom), rand_addr(),
                             SLOT_W'($urandom));
            else
                send_request(CMD_READ, DEV_W'($urandom), rand_addr(), SLOT_W'($urandom));
        end
    endtask

    // fill every slot dirty, then one sync emits the longest run of beats
    task automatic test_full_sync();
        write_slot_count(7'd64);
        stall_pct = 30;
        gap_max   = 0;
        for (int i = 0; i < SLOTS; i++)
            send_request(CMD_WRITE, i[4:0], ADDR_W'({$urandom, $urandom}), 6'd0);
        send_request(CMD_WRITE, 5'd9, 48'hdead_beef_0001, 6'd0);
        send_request(CMD_SYNC, 5'd0, '0, 6'd0);
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            tag_valid[i] = 1'b0;
            tag_dirty[i] = 1'b0;
            tag_dev[i]   = '0;
            tag_addr[i]  = '0;
            tag_used[i]  = '0;
        end
        tick_now  = '0;
        slots_reg = 7'd64;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_access();
        test_eviction();
        test_random_phase(7'd64, 30, 20, 0, 0);
        test_random_phase(7'd8, 50, 12, 40, 4);
        test_random_phase(7'd1, 35, 3, 20, 2);
        test_random_phase(7'd3, 45, 6, 60, 8);
        test_random_phase(7'd33, 50, 45, 10, 1);
        test_random_phase(7'd127, 30, 90, 50, 6);
        test_random_phase(7'($urandom_range(1, 64)), 50, 16, 25, 3);
        test_full_sync();

        drain_results();
        $display("sent %0d requests, checked %0d result beats, %0d with write-back",
                 beats_sent, beats_seen, writebacks);
        $display("slot counts from 0 to 127, LRU eviction, walks and aborts under stalls");
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
